### rtl/core/spi_master_phase_sequencer_macros.svh
// Assertion macros shared by the SPI master phase sequencer RTL.
`ifndef SPI_MASTER_PHASE_SEQUENCER_MACROS_SVH
`define SPI_MASTER_PHASE_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define SPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer check failed");
`define SPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer check failed");
`else
`define SPS_ASSERT_SAME(label, ante, cons)
`define SPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/sps_pkg.sv
// Shared constants and codes for the SPI master phase sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;
   localparam int BUFFER_WORDS_DEF = 16;
   localparam int SELECT_COUNT_DEF = 3;
   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;
   localparam int SEL_W = 3;
   localparam int POS_W = 7;
   localparam int IDX_W = 4;
   localparam int ACT_W = 2;
   localparam int REG_IDX_W = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_START = 2'd2,
      ACT_REPLY = 2'd3
   } action_type;

   typedef enum logic [REG_IDX_W-1:0] {
      CSR_PHASE_EN   = 3'd0,
      CSR_CMD_VALUE  = 3'd1,
      CSR_CMD_BITS   = 3'd2,
      CSR_ADDR_VALUE = 3'd3,
      CSR_ADDR_BITS  = 3'd4,
      CSR_DATA_BITS  = 3'd5,
      CSR_SEL_MASK   = 3'd6
   } csr_index_type;
endpackage
`default_nettype wire

### rtl/core/sps_channels.sv
// Handshake channel interfaces for request, response and register words.
`timescale 1ns / 1ps
`default_nettype none
interface sps_req_if import sps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [IDX_W-1:0]  word_index;
   logic [WORD_W-1:0] write_word;
   logic [BYTE_W-1:0] reply_byte;
   modport source (output valid, action, word_index, write_word, reply_byte, input ready);
   modport sink (input valid, action, word_index, write_word, reply_byte, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_word;
   logic [BYTE_W-1:0] send_byte;
   logic              send_valid;
   logic [SEL_W-1:0]  select_lines;
   logic              busy_res;
   logic              last;
   modport source (output valid, read_word, send_byte, send_valid, select_lines, busy_res,
                   last, input ready);
   modport sink (input valid, read_word, send_byte, send_valid, select_lines, busy_res,
                 last, output ready);
endinterface

interface sps_csr_if import sps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] reg_index;
   logic [WORD_W-1:0]    wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

### rtl/core/sps_buffer.sv
// Data buffer memory with byte-lane writes, per-word valid bits and registered read.
`timescale 1ns / 1ps
`default_nettype none
module sps_buffer import sps_pkg::*; #(
   parameter int BUFFER_WORDS = BUFFER_WORDS_DEF,
   localparam int AddrW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [AddrW-1:0]  wr_addr,
   input  wire logic [3:0]        wr_be,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AddrW-1:0]  rd_addr,
   output      logic [WORD_W-1:0] rd_data
);
   logic [3:0][BYTE_W-1:0] words_ff [BUFFER_WORDS];
   logic [BUFFER_WORDS-1:0] valid_ff;
   logic [WORD_W-1:0]       rd_word_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // A word never written reads as zero, so a partial write fills the other lanes with zero.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int l = 0; l < 4; l++) begin
            if (wr_be[l] || !valid_ff[wr_addr]) begin
               words_ff[wr_addr][l] <= wr_be[l] ? wr_data[BYTE_W*l +: BYTE_W] : '0;
            end
         end
      end
      if (rd_en) begin
         rd_word_ff  <= words_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;
endmodule
`default_nettype wire

### rtl/core/spi_master_phase_sequencer.sv
// Top level of the SPI master phase sequencer.
// A request word is registered in the stage register and then in the output register before
// its result is offered; a stalled response holds both registers.
// Throughput: one request word per cycle while the stage register can move on; a start with
// nothing to send yields two response words and holds the output register for the second.
// Reset returns the sequencing state and configuration registers to their defaults and clears the buffer valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "spi_master_phase_sequencer_macros.svh"
module spi_master_phase_sequencer import sps_pkg::*; #(
   parameter int BUFFER_WORDS = BUFFER_WORDS_DEF,
   parameter int SELECT_COUNT = SELECT_COUNT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   sps_req_if.sink   req_chan,
   sps_rsp_if.source rsp_chan,
   sps_csr_if.sink   csr_chan
);
   localparam int AddrW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
   localparam int DataCap = BUFFER_WORDS * 4;
   localparam logic [POS_W-1:0] DataCapPos = (DataCap > 64) ? 7'd64 : POS_W'(DataCap);
   localparam logic [SEL_W-1:0] SelIdle = SEL_W'((1 << SELECT_COUNT) - 1);
   localparam logic [7:0] BufWords8 = 8'(BUFFER_WORDS);

   typedef enum logic [1:0] {
      PH_CMD  = 2'd0,
      PH_ADDR = 2'd1,
      PH_DATA = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic              is_read;
      logic              mem_byte;
      logic              idx_ok;
      logic [1:0]        lane;
      logic [BYTE_W-1:0] byte_val;
      logic              send_valid;
      logic [SEL_W-1:0]  sel;
      logic              busy;
      logic              last;
      logic              two;
   } stage_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_word;
      logic [BYTE_W-1:0] send_byte;
      logic              send_valid;
      logic [SEL_W-1:0]  sel;
      logic              busy;
      logic              last;
   } rsp_type;

   // Configuration registers
   logic [3:0]        phase_en_ff;
   logic [15:0]       cmd_val_ff;
   logic [3:0]        cmd_bits_ff;
   logic [WORD_W-1:0] addr_val_ff;
   logic [4:0]        addr_bits_ff;
   logic [8:0]        data_bits_ff;
   logic [2:0]        sel_mask_ff;

   // Sequencing state and pipeline
   logic              active_ff, active_in;
   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   stage_type         stage_ff, stage_in;
   logic              stage_v_ff;
   rsp_type           out_ff, out_in;
   logic              out_v_ff;
   logic              second_ff;

   logic              req_accept, load_out;
   logic [POS_W-1:0]  cmd_len, addr_len, data_raw, data_len_any, data_len;
   phase_type         sph;
   logic [POS_W-1:0]  spos;
   logic [BYTE_W-1:0] b_val;
   logic              b_mem;
   logic [7:0]        data_idx8, rd_idx8, wr_idx8, st_idx8;
   logic              wr_en;
   logic [3:0]        wr_be;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] mem_q;
   logic [SEL_W-1:0]  start_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_en_ff  <= '0;
         cmd_val_ff   <= '0;
         cmd_bits_ff  <= '0;
         addr_val_ff  <= '0;
         addr_bits_ff <= '0;
         data_bits_ff <= '0;
         sel_mask_ff  <= 3'b111;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.reg_index)
            CSR_PHASE_EN:   phase_en_ff  <= csr_chan.wdata[3:0];
            CSR_CMD_VALUE:  cmd_val_ff   <= csr_chan.wdata[15:0];
            CSR_CMD_BITS:   cmd_bits_ff  <= csr_chan.wdata[3:0];
            CSR_ADDR_VALUE: addr_val_ff  <= csr_chan.wdata;
            CSR_ADDR_BITS:  addr_bits_ff <= csr_chan.wdata[4:0];
            CSR_DATA_BITS:  data_bits_ff <= csr_chan.wdata[8:0];
            CSR_SEL_MASK:   sel_mask_ff  <= csr_chan.wdata[2:0];
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // Phase lengths in bytes, taken from the live registers.
   always_comb begin
      cmd_len      = phase_en_ff[0] ? {6'd0, cmd_bits_ff[3]} + 7'd1 : '0;
      addr_len     = phase_en_ff[1] ? {5'd0, addr_bits_ff[4:3]} + 7'd1 : '0;
      data_raw     = {1'b0, data_bits_ff[8:3]} + 7'd1;
      data_len_any = (data_raw > DataCapPos) ? DataCapPos : data_raw;
      data_len     = (phase_en_ff[3:2] != 2'b00) ? data_len_any : '0;
   end

   // Skip every phase whose length is already used up; at most three steps.
   always_comb begin
      logic [POS_W-1:0] len;
      len = '0;
      if (req_chan.action == ACT_START) begin
         sph  = PH_CMD;
         spos = '0;
      end else begin
         sph  = phase_ff;
         spos = (phase_ff != PH_DONE) ? pos_ff + 7'd1 : pos_ff;
      end
      for (int k = 0; k < 3; k++) begin
         case (sph)
            PH_CMD:  len = cmd_len;
            PH_ADDR: len = addr_len;
            PH_DATA: len = data_len;
            default: len = '0;
         endcase
         if (sph != PH_DONE && spos >= len) begin
            case (sph)
               PH_CMD:  sph = PH_ADDR;
               PH_ADDR: sph = PH_DATA;
               default: sph = PH_DONE;
            endcase
            spos = '0;
         end
      end
   end

   // Byte to send at the settled position; data bytes come from the buffer when phase enable bit 2 is set, else zero.
   always_comb begin
      logic [1:0] a_idx;
      a_idx     = 2'(addr_len - 7'd1 - spos);
      b_val     = '0;
      b_mem     = 1'b0;
      data_idx8 = {3'd0, spos[6:2]};
      case (sph)
         PH_CMD: begin
            if (spos[6:1] == '0) begin
               b_val = cmd_val_ff[{spos[0], 3'b000} +: BYTE_W];
            end
         end
         PH_ADDR: begin
            if (spos < addr_len) begin
               b_val = addr_val_ff[{a_idx, 3'b000} +: BYTE_W];
            end
         end
         PH_DATA: b_mem = phase_en_ff[2];
         default: ;
      endcase
   end

   assign start_sel = sel_mask_ff & SelIdle;

   always_comb begin
      logic emit_byte;
      logic two;
      emit_byte = 1'b0;
      two       = 1'b0;
      active_in = active_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sel_in    = sel_ff;
      wr_en     = 1'b0;
      wr_be     = 4'hF;
      wr_data   = req_chan.write_word;
      wr_idx8   = {4'd0, req_chan.word_index};
      rd_idx8   = {4'd0, req_chan.word_index};
      st_idx8   = {3'd0, pos_ff[6:2]};
      stage_in  = '0;
      stage_in.lane = spos[1:0];
      stage_in.last = 1'b1;
      case (req_chan.action)
         ACT_WRITE: begin
            wr_en = (wr_idx8 < BufWords8);
         end
         ACT_READ: begin
            stage_in.is_read = 1'b1;
            stage_in.idx_ok  = (rd_idx8 < BufWords8);
         end
         ACT_START: begin
            if (!active_ff) begin
               if (sph == PH_DONE) begin
                  two           = 1'b1;
                  stage_in.last = 1'b0;
               end else begin
                  active_in = 1'b1;
                  sel_in    = start_sel;
                  phase_in  = sph;
                  pos_in    = spos;
                  emit_byte = 1'b1;
               end
            end
         end
         ACT_REPLY: begin
            if (active_ff) begin
               if (phase_ff == PH_DATA && phase_en_ff[3] && pos_ff < data_len_any) begin
                  wr_en   = (st_idx8 < BufWords8);
                  wr_idx8 = st_idx8;
                  wr_be   = 4'b0001 << pos_ff[1:0];
                  wr_data = {4{req_chan.reply_byte}};
               end
               if (sph == PH_DONE) begin
                  active_in = 1'b0;
                  sel_in    = SelIdle;
                  phase_in  = PH_CMD;
                  pos_in    = '0;
               end else begin
                  phase_in  = sph;
                  pos_in    = spos;
                  emit_byte = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (emit_byte) begin
         stage_in.send_valid = 1'b1;
         stage_in.byte_val   = b_val;
         stage_in.mem_byte   = b_mem;
         if (b_mem) begin
            rd_idx8         = data_idx8;
            stage_in.idx_ok = (data_idx8 < BufWords8);
         end
      end
      stage_in.two  = two;
      stage_in.sel  = two ? start_sel : sel_in;
      stage_in.busy = two ? 1'b1 : active_in;
   end

   assign load_out   = stage_v_ff && (!out_v_ff || (rsp_chan.ready && !second_ff));
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !stage_v_ff || load_out;

   sps_buffer #(
      .BUFFER_WORDS (BUFFER_WORDS)
   ) u_buffer (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && wr_en),
      .wr_addr (wr_idx8[AddrW-1:0]),
      .wr_be   (wr_be),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_idx8[AddrW-1:0]),
      .rd_data (mem_q)
   );

   always_comb begin
      out_in.read_word  = (stage_ff.is_read && stage_ff.idx_ok) ? mem_q : '0;
      out_in.send_byte  = stage_ff.mem_byte ?
                          (stage_ff.idx_ok ? mem_q[{stage_ff.lane, 3'b000} +: BYTE_W] : '0) :
                          stage_ff.byte_val;
      out_in.send_valid = stage_ff.send_valid;
      out_in.sel        = stage_ff.sel;
      out_in.busy       = stage_ff.busy;
      out_in.last       = stage_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         phase_ff   <= PH_CMD;
         pos_ff     <= '0;
         sel_ff     <= SelIdle;
         stage_v_ff <= 1'b0;
         out_v_ff   <= 1'b0;
         second_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            active_ff  <= active_in;
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            sel_ff     <= sel_in;
            stage_v_ff <= 1'b1;
            stage_ff   <= stage_in;
         end else if (load_out) begin
            stage_v_ff <= 1'b0;
         end
         if (load_out) begin
            out_v_ff  <= 1'b1;
            out_ff    <= out_in;
            second_ff <= stage_ff.two;
         end else if (out_v_ff && rsp_chan.ready) begin
            if (second_ff) begin
               // An empty transfer closes at once: selects raised, idle.
               out_ff    <= rsp_type'{read_word: '0, send_byte: '0, send_valid: 1'b0,
                                      sel: SelIdle, busy: 1'b0, last: 1'b1};
               second_ff <= 1'b0;
            end else begin
               out_v_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.read_word    = out_ff.read_word;
   assign rsp_chan.send_byte    = out_ff.send_byte;
   assign rsp_chan.send_valid   = out_ff.send_valid;
   assign rsp_chan.select_lines = out_ff.sel;
   assign rsp_chan.busy_res     = out_ff.busy;
   assign rsp_chan.last         = out_ff.last;

   `SPS_ASSERT_SAME(a_second_needs_output, second_ff, out_v_ff)
   `SPS_ASSERT_SAME(a_idle_at_origin, !active_ff, phase_ff == PH_CMD && pos_ff == '0 && sel_ff == SelIdle)
   `SPS_ASSERT_SAME(a_phase_never_done, 1'b1, phase_ff != PH_DONE)
   `SPS_ASSERT_NEXT(a_two_first_not_last, load_out && stage_ff.two, out_v_ff && second_ff && !out_ff.last)
endmodule
`default_nettype wire
